>>> rtl/acl_permission_check_top_defines.svh
// Assertion macros shared by the access-list checker RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ACL_PERMISSION_CHECK_TOP_DEFINES_SVH
`define ACL_PERMISSION_CHECK_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ACL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ACL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/acl_pkg.sv
// Types and constants for the access-list checker.
// Used by acl_table, acl_scan_unit, acl_ctrl and the top level.
package acl_pkg;

   localparam int TABLE_DEPTH = 8;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int ID_W        = 32;
   localparam int RIGHTS_W    = 3;
   localparam int KIND_W      = 3;
   localparam int COUNT_W     = 4;
   localparam int SLOT_W      = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CLASS_W     = 3;

   localparam logic [ID_W-1:0]    OWNER_USER_RESET  = 32'd1000;
   localparam logic [ID_W-1:0]    OWNER_GROUP_RESET = 32'd2000;
   localparam logic [COUNT_W-1:0] COUNT_RESET       = 4'd0;
   localparam logic [COUNT_W-1:0] DEPTH_COUNT       = COUNT_W'(TABLE_DEPTH);

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CHECK = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OWNER_USER  = 2'd0,
      CSR_OWNER_GROUP = 2'd1,
      CSR_ENTRY_COUNT = 2'd2
   } csr_idx_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_OWNER        = 3'd0,
      KIND_OWNING_GROUP = 3'd1,
      KIND_OTHER        = 3'd2,
      KIND_NAMED_USER   = 3'd3,
      KIND_NAMED_GROUP  = 3'd4,
      KIND_MASK         = 3'd5
   } kind_type;

   typedef enum logic [CLASS_W-1:0] {
      CLS_OWNER      = 3'd0,
      CLS_NAMED_USER = 3'd1,
      CLS_GROUP      = 3'd2,
      CLS_OTHER      = 3'd3,
      CLS_NONE       = 3'd4
   } class_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [ID_W-1:0]     id;
      logic [RIGHTS_W-1:0] rights;
   } entry_type;

   // First entry of each class seen so far in a scan.
   typedef struct packed {
      logic                owner_seen;
      logic                user_seen;
      logic                og_seen;
      logic                ng_seen;
      logic                mask_seen;
      logic                other_seen;
      logic [RIGHTS_W-1:0] owner_r;
      logic [RIGHTS_W-1:0] user_r;
      logic [RIGHTS_W-1:0] og_r;
      logic [RIGHTS_W-1:0] ng_r;
      logic [RIGHTS_W-1:0] mask_r;
      logic [RIGHTS_W-1:0] other_r;
   } acc_type;

   // Sequencer to scan unit.
   typedef struct packed {
      logic            clear;
      logic            step;
      logic [ID_W-1:0] user_id;
      logic [ID_W-1:0] group_id;
   } scan_ctl_type;

endpackage

>>> rtl/acl_table.sv
// Entry table of the access-list checker: register file with valid bits.
// Depends on acl_pkg; an entry never written reads as all zeros.
module acl_table (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [acl_pkg::SLOT_W-1:0] wr_slot,
   input  acl_pkg::entry_type         wr_entry,
   input  logic [acl_pkg::IDX_W-1:0]  rd_index,
   output acl_pkg::entry_type         rd_entry
);

   acl_pkg::entry_type                    entries_ff [acl_pkg::TABLE_DEPTH];
   logic [acl_pkg::TABLE_DEPTH-1:0]       valid_ff;
   logic                                  slot_ok;

   // Drop writes to slots past the table.
   assign slot_ok = (32'(wr_slot) < acl_pkg::TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en && slot_ok) begin
         valid_ff[wr_slot[acl_pkg::IDX_W-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && slot_ok) begin
         entries_ff[wr_slot[acl_pkg::IDX_W-1:0]] <= wr_entry;
      end
   end

   assign rd_entry = valid_ff[rd_index] ? entries_ff[rd_index] : '0;

endmodule

>>> rtl/acl_scan_unit.sv
// Shared id compare and class accumulator, one table entry per step.
// Depends on acl_pkg.
module acl_scan_unit (
   input  logic                 clock,
   input  acl_pkg::scan_ctl_type ctl,
   input  acl_pkg::entry_type   entry,
   output acl_pkg::acc_type     acc
);

   acl_pkg::acc_type            acc_ff;
   acl_pkg::acc_type            acc_in;
   logic [acl_pkg::ID_W-1:0]    cmp_id;
   logic                        id_match;

   // One comparator serves both named classes.
   assign cmp_id   = (entry.kind == acl_pkg::KIND_NAMED_GROUP) ? ctl.group_id : ctl.user_id;
   assign id_match = (entry.id == cmp_id);

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.step) begin
         unique case (entry.kind)
            acl_pkg::KIND_OWNER: begin
               if (!acc_ff.owner_seen) begin
                  acc_in.owner_seen = 1'b1;
                  acc_in.owner_r    = entry.rights;
               end
            end
            acl_pkg::KIND_NAMED_USER: begin
               if (!acc_ff.user_seen && id_match) begin
                  acc_in.user_seen = 1'b1;
                  acc_in.user_r    = entry.rights;
               end
            end
            acl_pkg::KIND_OWNING_GROUP: begin
               if (!acc_ff.og_seen) begin
                  acc_in.og_seen = 1'b1;
                  acc_in.og_r    = entry.rights;
               end
            end
            acl_pkg::KIND_NAMED_GROUP: begin
               if (!acc_ff.ng_seen && id_match) begin
                  acc_in.ng_seen = 1'b1;
                  acc_in.ng_r    = entry.rights;
               end
            end
            acl_pkg::KIND_MASK: begin
               if (!acc_ff.mask_seen) begin
                  acc_in.mask_seen = 1'b1;
                  acc_in.mask_r    = entry.rights;
               end
            end
            acl_pkg::KIND_OTHER: begin
               if (!acc_ff.other_seen) begin
                  acc_in.other_seen = 1'b1;
                  acc_in.other_r    = entry.rights;
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

>>> rtl/acl_ctrl.sv
// Sequencer of the access-list checker: scans the table (skipped when the entry count is zero), then decides.
// Depends on acl_pkg and acl_permission_check_top_defines.svh.
`include "acl_permission_check_top_defines.svh"

module acl_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         check_go,
   input  logic [acl_pkg::ID_W-1:0]     user_id,
   input  logic [acl_pkg::ID_W-1:0]     group_id,
   input  logic [acl_pkg::RIGHTS_W-1:0] wanted_rights,
   input  logic [acl_pkg::ID_W-1:0]     owner_user_id,
   input  logic [acl_pkg::ID_W-1:0]     owner_group_id,
   input  logic [acl_pkg::COUNT_W-1:0]  entry_count,
   input  acl_pkg::acc_type             acc,
   output acl_pkg::scan_ctl_type        scan_ctl,
   output logic [acl_pkg::IDX_W-1:0]    rd_index,
   output logic                         busy,
   output logic                         rsp_valid,
   output logic                         rsp_granted,
   output logic [acl_pkg::CLASS_W-1:0]  rsp_class
);

   acl_pkg::state_type                state_ff, state_in;
   logic [acl_pkg::COUNT_W-1:0]       scan_idx_ff, scan_idx_in;
   logic [acl_pkg::COUNT_W-1:0]       limit_ff, limit_in;
   logic [acl_pkg::COUNT_W-1:0]       count_clip;
   logic [acl_pkg::COUNT_W-1:0]       scan_idx_next;
   logic [acl_pkg::ID_W-1:0]          user_ff, user_in;
   logic [acl_pkg::ID_W-1:0]          group_ff, group_in;
   logic [acl_pkg::RIGHTS_W-1:0]      want_ff, want_in;
   logic                              user_owner_ff, user_owner_in;
   logic                              group_owner_ff, group_owner_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_granted_ff, rsp_granted_in;
   acl_pkg::class_type                rsp_class_ff, rsp_class_in;
   logic                              decide_grant;
   acl_pkg::class_type                decide_class;

   assign count_clip    = (entry_count > acl_pkg::DEPTH_COUNT) ? acl_pkg::DEPTH_COUNT
                                                               : entry_count;
   assign scan_idx_next = scan_idx_ff + 1'b1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         acl_pkg::ST_IDLE: begin
            if (check_go) begin
               state_in = (count_clip == '0) ? acl_pkg::ST_DECIDE : acl_pkg::ST_SCAN;
            end
         end
         acl_pkg::ST_SCAN: begin
            if (scan_idx_next == limit_ff) begin
               state_in = acl_pkg::ST_DECIDE;
            end
         end
         acl_pkg::ST_DECIDE: begin
            state_in = acl_pkg::ST_IDLE;
         end
         default: begin
            state_in = acl_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs toward the scan unit and table.
   always_comb begin
      scan_ctl.clear    = check_go;
      scan_ctl.step     = (state_ff == acl_pkg::ST_SCAN);
      scan_ctl.user_id  = user_ff;
      scan_ctl.group_id = group_ff;
      rd_index          = scan_idx_ff[acl_pkg::IDX_W-1:0];
      busy              = (state_ff != acl_pkg::ST_IDLE);
   end

   // Precedence: owner, named user, group (owning or named group, only when one grants), other, none.
   always_comb begin
      decide_grant = 1'b0;
      decide_class = acl_pkg::CLS_NONE;
      if (acc.owner_seen && user_owner_ff) begin
         decide_grant = ((acc.owner_r & want_ff) == want_ff);
         decide_class = acl_pkg::CLS_OWNER;
      end else if (acc.user_seen) begin
         decide_grant = ((acc.user_r & acc.mask_r & want_ff) == want_ff);
         decide_class = acl_pkg::CLS_NAMED_USER;
      end else if (acc.og_seen && group_owner_ff &&
                   ((acc.og_r & acc.mask_r & want_ff) == want_ff)) begin
         decide_grant = 1'b1;
         decide_class = acl_pkg::CLS_GROUP;
      end else if (acc.ng_seen && ((acc.ng_r & acc.mask_r & want_ff) == want_ff)) begin
         decide_grant = 1'b1;
         decide_class = acl_pkg::CLS_GROUP;
      end else if (acc.other_seen) begin
         decide_grant = ((acc.other_r & want_ff) == want_ff);
         decide_class = acl_pkg::CLS_OTHER;
      end
   end

   // Datapath next values.
   always_comb begin
      scan_idx_in    = scan_idx_ff;
      limit_in       = limit_ff;
      user_in        = user_ff;
      group_in       = group_ff;
      want_in        = want_ff;
      user_owner_in  = user_owner_ff;
      group_owner_in = group_owner_ff;
      rsp_valid_in   = (state_ff == acl_pkg::ST_DECIDE);
      rsp_granted_in = rsp_granted_ff;
      rsp_class_in   = rsp_class_ff;
      if (check_go) begin
         scan_idx_in    = '0;
         limit_in       = count_clip;
         user_in        = user_id;
         group_in       = group_id;
         want_in        = wanted_rights;
         user_owner_in  = (user_id == owner_user_id);
         group_owner_in = (group_id == owner_group_id);
      end else if (state_ff == acl_pkg::ST_SCAN) begin
         scan_idx_in = scan_idx_next;
      end
      if (state_ff == acl_pkg::ST_DECIDE) begin
         rsp_granted_in = decide_grant;
         rsp_class_in   = decide_class;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         scan_idx_ff  <= '0;
         limit_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_idx_ff  <= scan_idx_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      user_ff        <= user_in;
      group_ff       <= group_in;
      want_ff        <= want_in;
      user_owner_ff  <= user_owner_in;
      group_owner_ff <= group_owner_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_class_ff   <= rsp_class_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_class   = rsp_class_ff;

   `ACL_ASSERT_NEXT(a_decide_strobes, clock, reset, state_ff == acl_pkg::ST_DECIDE, rsp_valid_ff, "decide cycle did not produce a result")
   `ACL_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_valid_ff, state_ff == acl_pkg::ST_IDLE, "result strobe outside idle")
   `ACL_ASSERT_NOW(a_scan_bound, clock, reset, state_ff == acl_pkg::ST_SCAN, (scan_idx_ff < limit_ff) && (limit_ff <= acl_pkg::DEPTH_COUNT), "scan index past entry count")
   `ACL_ASSERT_NEXT(a_check_busy, clock, reset, check_go, state_ff != acl_pkg::ST_IDLE, "accepted check did not start")

endmodule

>>> rtl/acl_permission_check_top.sv
// Check: one table entry per cycle through a shared compare unit, then a decide
// state; the scan covers min(entry_count, 8) entries and the result strobe is
// registered from decide. busy is high from accept until the strobe and blocks new
// requests; writes never raise busy. Results cannot be stalled. Reset (synchronous):
// owner_user_id 1000, owner_group_id 2000, entry_count 0, every entry reads zero.
// Depends on acl_pkg, acl_table, acl_scan_unit, acl_ctrl.
module acl_permission_check_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_command,
   input  logic [acl_pkg::SLOT_W-1:0]     req_entry_index,
   input  logic [acl_pkg::KIND_W-1:0]     req_entry_kind,
   input  logic [acl_pkg::ID_W-1:0]       req_entry_id,
   input  logic [acl_pkg::RIGHTS_W-1:0]   req_entry_rights,
   input  logic [acl_pkg::ID_W-1:0]       req_user_id,
   input  logic [acl_pkg::ID_W-1:0]       req_group_id,
   input  logic [acl_pkg::RIGHTS_W-1:0]   req_wanted_rights,
   output logic                           rsp_strobe,
   output logic                           rsp_granted,
   output logic [acl_pkg::CLASS_W-1:0]    rsp_deciding_class,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [acl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [acl_pkg::ID_W-1:0]       csr_wdata
);

   logic [acl_pkg::ID_W-1:0]    owner_user_ff;
   logic [acl_pkg::ID_W-1:0]    owner_group_ff;
   logic [acl_pkg::COUNT_W-1:0] entry_count_ff;
   logic                        item_go;
   logic                        write_go;
   logic                        check_go;
   logic                        csr_go;
   acl_pkg::entry_type          wr_entry;
   acl_pkg::entry_type          rd_entry;
   logic [acl_pkg::IDX_W-1:0]   rd_index;
   acl_pkg::scan_ctl_type       scan_ctl;
   acl_pkg::acc_type            acc;

   assign item_go  = start && !busy;
   assign write_go = item_go && (req_command == acl_pkg::CMD_WRITE);
   assign check_go = item_go && (req_command == acl_pkg::CMD_CHECK);

   assign csr_ready = 1'b1;
   assign csr_go    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_user_ff  <= acl_pkg::OWNER_USER_RESET;
         owner_group_ff <= acl_pkg::OWNER_GROUP_RESET;
         entry_count_ff <= acl_pkg::COUNT_RESET;
      end else if (csr_go) begin
         unique case (csr_index)
            acl_pkg::CSR_OWNER_USER:  owner_user_ff  <= csr_wdata;
            acl_pkg::CSR_OWNER_GROUP: owner_group_ff <= csr_wdata;
            acl_pkg::CSR_ENTRY_COUNT: entry_count_ff <= csr_wdata[acl_pkg::COUNT_W-1:0];
            default: begin
               owner_user_ff <= owner_user_ff;
            end
         endcase
      end
   end

   assign wr_entry.kind   = req_entry_kind;
   assign wr_entry.id     = req_entry_id;
   assign wr_entry.rights = req_entry_rights;

   acl_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (write_go),
      .wr_slot  (req_entry_index),
      .wr_entry (wr_entry),
      .rd_index (rd_index),
      .rd_entry (rd_entry)
   );

   acl_scan_unit u_scan (
      .clock (clock),
      .ctl   (scan_ctl),
      .entry (rd_entry),
      .acc   (acc)
   );

   acl_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .check_go       (check_go),
      .user_id        (req_user_id),
      .group_id       (req_group_id),
      .wanted_rights  (req_wanted_rights),
      .owner_user_id  (owner_user_ff),
      .owner_group_id (owner_group_ff),
      .entry_count    (entry_count_ff),
      .acc            (acc),
      .scan_ctl       (scan_ctl),
      .rd_index       (rd_index),
      .busy           (busy),
      .rsp_valid      (rsp_strobe),
      .rsp_granted    (rsp_granted),
      .rsp_class      (rsp_deciding_class)
   );

endmodule
